@@ rtl/core/dcsp_pkg.sv @@
// Package for the caption service block parser: parse phases, command codes,
// the parsed-operation struct and the argument-skip lookup functions.
// No dependencies.
`default_nettype none

package dcsp_pkg;

  // Parser phases; code 7 is unused and behaves as trailing skip
  typedef enum logic [2:0] {
    PH_PKT   = 3'd0,
    PH_SVC   = 3'd1,
    PH_XSVC  = 3'd2,
    PH_BLOCK = 3'd3,
    PH_EXT1  = 3'd4,
    PH_SKIP  = 3'd5,
    PH_TRAIL = 3'd6
  } phase_t;

  typedef enum logic {
    EVT_APPEND    = 1'b0,
    EVT_BACKSPACE = 1'b1
  } evt_kind_t;

  // Command and character codes
  localparam logic [7:0] C_BS        = 8'h08;
  localparam logic [7:0] C_EXT1      = 8'h10;
  localparam logic [7:0] C_P16       = 8'h18;
  localparam logic [7:0] C_PRINT_LO  = 8'h20;
  localparam logic [7:0] C_DEL       = 8'h7F;
  localparam logic [7:0] C1_SKIP1_LO = 8'h88;
  localparam logic [7:0] C1_SKIP1_HI = 8'h8D;
  localparam logic [7:0] C1_SKIP2_A  = 8'h90;
  localparam logic [7:0] C1_SKIP3    = 8'h91;
  localparam logic [7:0] C1_SKIP2_B  = 8'h92;
  localparam logic [7:0] C1_SKIP4    = 8'h97;
  localparam logic [7:0] C1_SKIP6_LO = 8'h98;
  localparam logic [7:0] C1_SKIP6_HI = 8'h9F;
  localparam logic [7:0] X_SKIP1_LO  = 8'h08;
  localparam logic [7:0] X_SKIP4_LO  = 8'h80;
  localparam logic [7:0] X_SKIP5_HI  = 8'h8F;

  localparam logic [2:0] SVC_EXTENDED = 3'd7;
  localparam logic [15:0] MUSIC_NOTE  = 16'h266A;
  localparam logic [1:0] CC_START     = 2'd3;

  // One parsed count operation headed for the count store
  typedef struct packed {
    logic        valid;
    evt_kind_t   kind;
    logic [5:0]  svc;
    logic [15:0] code;
  } op_t;

  // Argument bytes following a C1 command
  function automatic logic [2:0] c1_skip(input logic [7:0] b);
    logic [2:0] n;
    n = 3'd0;
    if (b >= C1_SKIP1_LO && b <= C1_SKIP1_HI) n = 3'd1;
    else if (b == C1_SKIP2_A || b == C1_SKIP2_B) n = 3'd2;
    else if (b == C1_SKIP3) n = 3'd3;
    else if (b == C1_SKIP4) n = 3'd4;
    else if (b >= C1_SKIP6_LO && b <= C1_SKIP6_HI) n = 3'd6;
    return n;
  endfunction

  // Argument bytes following an EXT1 code byte
  function automatic logic [2:0] ext1_skip(input logic [7:0] b);
    logic [2:0] n;
    n = 3'd0;
    if (b >= X_SKIP1_LO && b < C_EXT1) n = 3'd1;
    else if (b >= C_EXT1 && b < C_P16) n = 3'd2;
    else if (b >= C_P16 && b < C_PRINT_LO) n = 3'd3;
    else if (b >= X_SKIP4_LO && b < C1_SKIP1_LO) n = 3'd4;
    else if (b >= C1_SKIP1_LO && b <= X_SKIP5_HI) n = 3'd5;
    return n;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/dcsp_if.sv @@
// Valid/ready channel interfaces for caption bytes in and caption events out.
// Depends on nothing.
`default_nettype none

interface dcsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic [1:0] cc_type;

  modport source (output valid, output data_byte, output cc_type, input ready);
  modport sink   (input valid, input data_byte, input cc_type, output ready);
endinterface

interface dcsp_out_if;
  logic        valid;
  logic        ready;
  logic        event_kind;
  logic [5:0]  service;
  logic [15:0] char_code;

  modport source (output valid, output event_kind, output service, output char_code,
                  input ready);
  modport sink   (input valid, input event_kind, input service, input char_code,
                  output ready);
endinterface

`default_nettype wire

@@ rtl/core/dcsp_parser.sv @@
// Byte-level packet/service/block parser state machine. Uses dcsp_pkg.
// Emits one count operation per printable or backspace byte inside a block.
`default_nettype none

module dcsp_parser (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           take,
  input  wire logic [7:0]     data_byte,
  input  wire logic [1:0]     cc_type,
  output dcsp_pkg::op_t       op
);
  import dcsp_pkg::*;

  logic       accepted, accepted_next;
  phase_t     phase, phase_next;
  logic [6:0] packet_left, packet_left_next;
  logic [4:0] block_left, block_left_next;
  logic [2:0] skip_left, skip_left_next;
  logic [5:0] current_service, current_service_next;

  // Byte is parsed once the stream has locked onto a packet start
  logic   active;
  phase_t ph;
  assign active = take && (accepted || cc_type == CC_START);
  assign ph     = accepted ? phase : PH_PKT;

  // Next state
  always_comb begin
    logic [6:0] pl;
    logic [4:0] bl;
    logic [2:0] sl;
    logic [5:0] size;
    accepted_next        = accepted;
    phase_next           = phase;
    packet_left_next     = packet_left;
    block_left_next      = block_left;
    skip_left_next       = skip_left;
    current_service_next = current_service;
    pl   = packet_left - 7'd1;
    bl   = block_left;
    sl   = skip_left;
    size = data_byte[5:0];
    if (active) begin
      accepted_next = 1'b1;
      if (ph == PH_PKT) begin
        block_left_next = '0;
        skip_left_next  = '0;
        if (size != '0) begin
          packet_left_next = {size, 1'b0} - 7'd1;
          phase_next       = PH_SVC;
        end else begin
          packet_left_next = '0;
          phase_next       = PH_PKT;
        end
      end else begin
        packet_left_next = pl;
        unique case (ph)
          PH_SVC: begin
            current_service_next = {3'b000, data_byte[7:5]};
            bl = data_byte[4:0];
            if (data_byte[7:5] == SVC_EXTENDED) phase_next = PH_XSVC;
            else phase_next = (bl != '0) ? PH_BLOCK : PH_TRAIL;
          end
          PH_XSVC: begin
            current_service_next = data_byte[5:0];
            phase_next = (bl != '0) ? PH_BLOCK : PH_TRAIL;
          end
          PH_BLOCK: begin
            bl = block_left - 5'd1;
            sl = '0;
            if (data_byte == C_EXT1) begin
              phase_next = PH_EXT1;
            end else begin
              if (data_byte == C_P16) sl = 3'd2;
              else if (data_byte < C_PRINT_LO || data_byte > C_DEL) begin
                sl = c1_skip(data_byte);
              end
              phase_next = (sl != '0) ? PH_SKIP : ((bl != '0) ? PH_BLOCK : PH_TRAIL);
            end
          end
          PH_EXT1: begin
            if (bl != '0) bl = bl - 5'd1;
            sl = ext1_skip(data_byte);
            phase_next = (sl != '0) ? PH_SKIP : ((bl != '0) ? PH_BLOCK : PH_TRAIL);
          end
          PH_SKIP: begin
            if (bl != '0) bl = bl - 5'd1;
            if (sl != '0) sl = sl - 3'd1;
            phase_next = (sl != '0) ? PH_SKIP : ((bl != '0) ? PH_BLOCK : PH_TRAIL);
          end
          default: phase_next = PH_TRAIL;
        endcase
        block_left_next = bl;
        skip_left_next  = sl;
        // Last packet byte: back to the header, pending skips dropped
        if (pl == '0) begin
          phase_next      = PH_PKT;
          block_left_next = '0;
          skip_left_next  = '0;
        end
      end
    end
  end

  // Outputs: count operation for the byte being taken
  always_comb begin
    op       = '0;
    op.svc   = current_service;
    op.kind  = EVT_APPEND;
    op.code  = (data_byte == C_DEL) ? MUSIC_NOTE : {8'h00, data_byte};
    if (active && ph == PH_BLOCK) begin
      if (data_byte >= C_PRINT_LO && data_byte <= C_DEL) begin
        op.valid = 1'b1;
      end else if (data_byte == C_BS) begin
        op.valid = 1'b1;
        op.kind  = EVT_BACKSPACE;
        op.code  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accepted        <= 1'b0;
      phase           <= PH_PKT;
      packet_left     <= '0;
      block_left      <= '0;
      skip_left       <= '0;
      current_service <= '0;
    end else begin
      accepted        <= accepted_next;
      phase           <= phase_next;
      packet_left     <= packet_left_next;
      block_left      <= block_left_next;
      skip_left       <= skip_left_next;
      current_service <= current_service_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/dcsp_counts.sv @@
// Per-service character count store and event output stage.
// Registered memory read, one-deep write bypass, output register. Uses dcsp_pkg.
`default_nettype none

module dcsp_counts #(
  parameter int MAX_SERVICES = 64,
  parameter int COUNT_WIDTH  = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        take,
  input  dcsp_pkg::op_t    op,
  output logic             in_ready,
  dcsp_out_if.source       evt
);
  import dcsp_pkg::*;

  localparam int AW = (MAX_SERVICES > 1) ? $clog2(MAX_SERVICES) : 1;
  localparam logic [6:0] SVC_LIMIT = 7'(MAX_SERVICES);

  logic [COUNT_WIDTH-1:0] count_mem [MAX_SERVICES];
  logic [MAX_SERVICES-1:0] vld;

  // Operation stage (input register) with its count read
  logic                   s1_valid;
  op_t                    s1_op;
  logic [COUNT_WIDTH-1:0] rd_q;
  logic                   vld_q;
  logic                   byp;
  logic [COUNT_WIDTH-1:0] byp_val;

  logic                   s1_go, load, has, emit, wr_en;
  logic [COUNT_WIDTH-1:0] cur, wr_data;
  logic [AW-1:0]          wr_addr, rd_addr;

  assign s1_go    = s1_valid && (!evt.valid || evt.ready);
  assign in_ready = !s1_valid || s1_go;
  assign load     = take && op.valid;
  assign rd_addr  = op.svc[AW-1:0];
  assign wr_addr  = s1_op.svc[AW-1:0];

  // Count update and event decision
  always_comb begin
    has  = {1'b0, s1_op.svc} < SVC_LIMIT;
    cur  = byp ? byp_val : (vld_q ? rd_q : '0);
    if (s1_op.kind == EVT_APPEND) begin
      wr_data = (cur == '1) ? cur : cur + 1'b1;
      emit    = 1'b1;
      wr_en   = s1_go && has;
    end else begin
      wr_data = cur - 1'b1;
      emit    = has && (cur != '0);
      wr_en   = s1_go && emit;
    end
  end

  // Count memory
  always_ff @(posedge clk) begin
    if (wr_en) count_mem[wr_addr] <= wr_data;
    if (load)  rd_q <= count_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_op   <= op;
      vld_q   <= vld[rd_addr];
      byp     <= wr_en && (wr_addr == rd_addr);
      byp_val <= wr_data;
    end
  end

  // Entry valid bits and stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      vld      <= '0;
      s1_valid <= 1'b0;
    end else begin
      if (wr_en) vld[wr_addr] <= 1'b1;
      if (in_ready) s1_valid <= load;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      evt.valid <= 1'b0;
    end else if (s1_go && emit) begin
      evt.valid <= 1'b1;
    end else if (evt.ready) begin
      evt.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && emit) begin
      evt.event_kind <= s1_op.kind;
      evt.service    <= s1_op.svc;
      evt.char_code  <= s1_op.code;
    end
  end

  // Backspace events only come from services that keep a count
  a_bs_has_count: assert property (@(posedge clk) disable iff (rst)
    evt.valid && evt.event_kind == EVT_BACKSPACE |-> {1'b0, evt.service} < SVC_LIMIT)
    else $error("backspace event from service without count");

  // No count write while the stage is held by a stalled output
  a_no_write_on_stall: assert property (@(posedge clk) disable iff (rst)
    evt.valid && !evt.ready |-> !wr_en)
    else $error("count written during output stall");

  // Reset empties the store
  a_reset_clears: assert property (@(posedge clk) rst |=> vld == '0)
    else $error("valid bits not cleared by reset");

endmodule

`default_nettype wire

@@ rtl/core/dtvcc_caption_service_parser.sv @@
// Top level of the caption service block parser: byte parser plus count store.
// Depends on dcsp_pkg, dcsp_if, dcsp_parser and dcsp_counts.
//
//   channel   dir   payload                          transaction
//   cap_in    in    data_byte[7:0], cc_type[1:0]     valid && ready
//   evt_out   out   event_kind, service, char_code   valid && ready
//
// One byte is accepted per cycle; a stalled event output holds the operation
// stage and stops byte intake. Events pass the operation stage, then the output
// register. The byte rate is set by the per-service count read-modify-write,
// pipelined with a one-deep write bypass. Reset (rst, synchronous) clears parser
// state, the output register and the count valid bits at once; no clearing pass.
`default_nettype none

module dtvcc_caption_service_parser #(
  parameter int MAX_SERVICES = 64,
  parameter int COUNT_WIDTH  = 16
) (
  input  wire logic    clk,
  input  wire logic    rst,
  dcsp_in_if.sink      cap_in,
  dcsp_out_if.source   evt_out
);
  import dcsp_pkg::*;

  op_t  op;
  logic in_ready;
  logic take;

  assign cap_in.ready = in_ready;
  assign take         = cap_in.valid && in_ready;

  dcsp_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .data_byte (cap_in.data_byte),
    .cc_type   (cap_in.cc_type),
    .op        (op)
  );

  dcsp_counts #(
    .MAX_SERVICES (MAX_SERVICES),
    .COUNT_WIDTH  (COUNT_WIDTH)
  ) u_counts (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .op       (op),
    .in_ready (in_ready),
    .evt      (evt_out)
  );

endmodule

`default_nettype wire

@@ test/tb_dtvcc_caption_service_parser.sv @@
// Testbench for the caption service block parser: drives caption bytes, predicts
// append and backspace events, and checks every event transaction in order.
// Depends on dcsp_pkg, dcsp_if and the dtvcc_caption_service_parser RTL.
`timescale 1ns / 1ps

module tb_dtvcc_caption_service_parser;
  import dcsp_pkg::*;

  localparam int SVC_SLOTS    = 64;
  localparam int COUNT_W      = 16;
  localparam int EVT_LATENCY  = 2;
  localparam int DRAIN_CYCLES = 4 * EVT_LATENCY;
  localparam int MAX_GAP      = 13;
  localparam int HOLD_CYCLES  = 300;
  localparam int IDLE_LIMIT   = 4000;
  localparam int RANDOM_ITEMS = 750;
  localparam int MAX_REPORTS  = 10;
  // 31 characters per packet; more backspace packets than append packets
  localparam int COUNT_UP_PKTS   = 2;
  localparam int COUNT_DOWN_PKTS = 3;

  typedef logic [7:0] byte_q_t[$];

  typedef struct packed {
    evt_kind_t   kind;
    logic [5:0]  svc;
    logic [15:0] code;
  } caption_event_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  dcsp_in_if  cap_if ();
  dcsp_out_if evt_if ();

  dtvcc_caption_service_parser DUT (
    .clk(clk),
    .rst(rst),
    .cap_in(cap_if),
    .evt_out(evt_if)
  );

  always #2 clk = ~clk;

  // Predicted parser state
  logic               synced = 1'b0;
  phase_t             parse_phase = PH_PKT;
  logic [6:0]         pkt_remaining = '0;
  logic [4:0]         blk_remaining = '0;
  logic [2:0]         arg_remaining = '0;
  logic [5:0]         active_svc = '0;
  logic [COUNT_W-1:0] svc_chars [SVC_SLOTS];

  caption_event_t pending_events[$];
  int unsigned    bad_events = 0;
  int unsigned    sent_bytes = 0;
  int unsigned    stall_cycles = 0;
  bit             tx_idle_on = 1'b1;
  bit             rx_idle_on = 1'b1;
  bit             hold_req = 1'b0;
  bit             rx_hold = 1'b0;

  initial begin
    foreach (svc_chars[i]) svc_chars[i] = '0;
  end

  // Argument bytes after a C1 command
  function automatic logic [2:0] c1_args(input logic [7:0] b);
    if (b >= C1_SKIP1_LO && b <= C1_SKIP1_HI) return 3'd1;
    if (b == C1_SKIP2_A || b == C1_SKIP2_B) return 3'd2;
    if (b == C1_SKIP3) return 3'd3;
    if (b == C1_SKIP4) return 3'd4;
    if (b >= C1_SKIP6_LO && b <= C1_SKIP6_HI) return 3'd6;
    return 3'd0;
  endfunction

  // Argument bytes after the code byte of an EXT1 sequence
  function automatic logic [2:0] ext1_args(input logic [7:0] b);
    if (b >= X_SKIP1_LO && b < C_EXT1) return 3'd1;
    if (b >= C_EXT1 && b < C_P16) return 3'd2;
    if (b >= C_P16 && b < C_PRINT_LO) return 3'd3;
    if (b >= X_SKIP4_LO && b < C1_SKIP1_LO) return 3'd4;
    if (b >= C1_SKIP1_LO && b <= X_SKIP5_HI) return 3'd5;
    return 3'd0;
  endfunction

  function automatic phase_t next_after_cmd();
    if (arg_remaining != 0) return PH_SKIP;
    return (blk_remaining != 0) ? PH_BLOCK : PH_TRAIL;
  endfunction

  // Advance the predicted parser by one accepted byte, queue any event
  function automatic void parse_caption_byte(input logic [7:0] b, input logic [1:0] ct);
    caption_event_t ev;
    if (!synced) begin
      if (ct != CC_START) return;
      synced = 1'b1;
      parse_phase = PH_PKT;
    end
    if (parse_phase == PH_PKT) begin
      blk_remaining = '0;
      arg_remaining = '0;
      if (b[5:0] != 0) begin
        pkt_remaining = {b[5:0], 1'b0} - 7'd1;
        parse_phase = PH_SVC;
      end else begin
        pkt_remaining = '0;
      end
      return;
    end
    pkt_remaining = pkt_remaining - 7'd1;
    case (parse_phase)
      PH_SVC: begin
        active_svc = {3'b000, b[7:5]};
        blk_remaining = b[4:0];
        if (b[7:5] == SVC_EXTENDED) parse_phase = PH_XSVC;
        else parse_phase = (blk_remaining != 0) ? PH_BLOCK : PH_TRAIL;
      end
      PH_XSVC: begin
        active_svc = b[5:0];
        parse_phase = (blk_remaining != 0) ? PH_BLOCK : PH_TRAIL;
      end
      PH_BLOCK: begin
        blk_remaining = blk_remaining - 5'd1;
        arg_remaining = '0;
        if (b >= C_PRINT_LO && b <= C_DEL) begin
          if (svc_chars[active_svc] != '1)
            svc_chars[active_svc] = svc_chars[active_svc] + 1'b1;
          ev.kind = EVT_APPEND;
          ev.svc  = active_svc;
          ev.code = (b == C_DEL) ? MUSIC_NOTE : {8'h00, b};
          pending_events.push_back(ev);
          parse_phase = next_after_cmd();
        end else if (b == C_BS) begin
          if (svc_chars[active_svc] != 0) begin
            svc_chars[active_svc] = svc_chars[active_svc] - 1'b1;
            ev.kind = EVT_BACKSPACE;
            ev.svc  = active_svc;
            ev.code = '0;
            pending_events.push_back(ev);
          end
          parse_phase = next_after_cmd();
        end else if (b == C_EXT1) begin
          parse_phase = PH_EXT1;
        end else begin
          arg_remaining = (b == C_P16) ? 3'd2 : c1_args(b);
          parse_phase = next_after_cmd();
        end
      end
      PH_EXT1: begin
        if (blk_remaining != 0) blk_remaining = blk_remaining - 5'd1;
        arg_remaining = ext1_args(b);
        parse_phase = next_after_cmd();
      end
      PH_SKIP: begin
        if (blk_remaining != 0) blk_remaining = blk_remaining - 5'd1;
        if (arg_remaining != 0) arg_remaining = arg_remaining - 3'd1;
        parse_phase = next_after_cmd();
      end
      default: parse_phase = PH_TRAIL;
    endcase
    // last byte of the packet: back to header, pending skips dropped
    if (pkt_remaining == 0) begin
      parse_phase = PH_PKT;
      blk_remaining = '0;
      arg_remaining = '0;
    end
  endfunction

  // Offer one byte, hold it until the transaction completes, then predict
  task automatic send_byte(input logic [7:0] b, input logic [1:0] ct);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      cap_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cap_if.valid     <= 1'b1;
    cap_if.data_byte <= b;
    cap_if.cc_type   <= ct;
    @(posedge clk);
    while (!cap_if.ready) @(posedge clk);
    sent_bytes++;
    parse_caption_byte(b, ct);
  endtask

  task automatic send_packet(input byte_q_t pkt);
    foreach (pkt[i]) send_byte(pkt[i], 2'($urandom_range(0, 3)));
  endtask

  // Sender pause: nothing offered until every predicted event is out
  task automatic wait_drained();
    cap_if.valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Block byte biased toward characters, backspace and commands
  function automatic logic [7:0] pick_block_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 8'($urandom_range(C_PRINT_LO, C_DEL));
    if (r < 65) return C_BS;
    if (r < 72) return C_EXT1;
    if (r < 77) return C_P16;
    if (r < 90) return 8'($urandom_range(8'h80, 8'h9F));
    return 8'($urandom);
  endfunction

  // Packet with a service block of random content; size mostly fits the block
  task automatic send_random_packet();
    byte_q_t    pkt;
    logic [2:0] svc3;
    logic [4:0] blk;
    int         body, size, keep;
    svc3 = 3'($urandom);
    blk  = ($urandom_range(0, 9) < 7) ? 5'($urandom_range(0, 10)) : 5'($urandom);
    pkt.push_back({svc3, blk});
    if (svc3 == SVC_EXTENDED) pkt.push_back(8'($urandom));
    body = blk + $urandom_range(0, 4);
    repeat (body) pkt.push_back(pick_block_byte());
    if ($urandom_range(0, 29) == 0) size = 63;
    else if ($urandom_range(0, 4) != 0) size = (pkt.size() + 2) / 2 + $urandom_range(0, 2);
    else size = $urandom_range(0, 12);
    if (size > 63) size = 63;
    pkt.push_front({2'($urandom), 6'(size)});
    keep = (size == 0) ? 1 : size * 2;
    while (pkt.size() < keep) pkt.push_back(8'($urandom));
    while (pkt.size() > keep) void'(pkt.pop_back());
    send_packet(pkt);
  endtask

  // Bytes before the first start-tagged byte are dropped
  task automatic test_pre_sync();
    send_byte(8'hFF, 2'd0);
    send_byte(8'h05, 2'd1);
    send_byte(8'h45, 2'd2);
    // start-tagged empty packet
    send_byte({2'b11, 6'd0}, CC_START);
  endtask

  task automatic test_directed();
    byte_q_t pkt;
    // empty block: rest of the packet skipped
    pkt = '{8'h01, 8'h20};
    send_packet(pkt);
    // backspace on empty count, printable extremes, music note, '='
    pkt = '{8'h04, 8'h26, C_BS, C_PRINT_LO, C_DEL, C_BS, 8'h7E, 8'h3D};
    send_packet(pkt);
    // extended service 63 with marks set; EXT1 args cut by packet end
    pkt = '{8'h83, 8'hE3, 8'hFF, C_EXT1, C1_SKIP1_LO, 8'h41};
    send_packet(pkt);
    // args run past block end, then trailing bytes
    pkt = '{8'h05, 8'h42, 8'h3D, C1_SKIP4, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46};
    send_packet(pkt);
    wait_drained();
  endtask

  // Build up one count, then backspace it down to zero and past it
  task automatic test_count_run();
    byte_q_t pkt;
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    for (int p = 0; p < COUNT_UP_PKTS + COUNT_DOWN_PKTS; p++) begin
      pkt = {};
      pkt.push_back({p[1:0], 6'd17});
      pkt.push_back({3'd5, 5'd31});
      repeat (31) begin
        if (p < COUNT_UP_PKTS) pkt.push_back(8'($urandom_range(C_PRINT_LO, C_DEL)));
        else pkt.push_back(C_BS);
      end
      pkt.push_back(8'($urandom));
      send_packet(pkt);
    end
    wait_drained();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  // Output held off while the sender keeps offering bytes
  task automatic test_backpressure();
    byte_q_t pkt;
    tx_idle_on = 1'b0;
    hold_req = 1'b1;
    repeat (2) begin
      pkt = {};
      pkt.push_back({2'b01, 6'd17});
      pkt.push_back({3'd3, 5'd31});
      repeat (31) pkt.push_back(8'($urandom_range(C_PRINT_LO, C_DEL)));
      pkt.push_back(8'($urandom));
      send_packet(pkt);
    end
    wait_drained();
    tx_idle_on = 1'b1;
  endtask

  // Mostly well-formed packets, with noise bytes and occasional drains
  task automatic test_random();
    int unsigned start;
    start = sent_bytes;
    while (sent_bytes < start + RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) == 0) tx_idle_on = !tx_idle_on;
      if ($urandom_range(0, 9) == 0) rx_idle_on = !rx_idle_on;
      if ($urandom_range(0, 19) == 0)
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom), 2'($urandom_range(0, 3)));
      else
        send_random_packet();
      if ($urandom_range(0, 24) == 0) wait_drained();
    end
  endtask

  // Main sequence
  initial begin
    cap_if.valid     <= 1'b0;
    cap_if.data_byte <= '0;
    cap_if.cc_type   <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_pre_sync();
    test_directed();
    test_count_run();
    test_backpressure();
    test_random();
    wait_drained();
    if (bad_events == 0)
      $display("dtvcc_caption_service_parser: match");
    else
      $display("dtvcc_caption_service_parser: mismatch");
    $finish;
  end

  // Long receiver hold-off, counted here
  initial begin
    wait (hold_req);
    rx_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold = 1'b0;
  end

  task automatic note_bad(input string what, input caption_event_t want,
                          input caption_event_t got);
    if (bad_events < MAX_REPORTS)
      $display("%s: expected kind %0d svc %0d code %h, got kind %0d svc %0d code %h",
               what, want.kind, want.svc, want.code, got.kind, got.svc, got.code);
    bad_events++;
  endtask

  // Event receiver and checker
  initial begin
    caption_event_t got, want;
    int gap;
    evt_if.ready <= 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (rx_hold) begin
        evt_if.ready <= 1'b0;
        while (rx_hold) @(posedge clk);
      end
      gap = rx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
      if (gap > 0) begin
        evt_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      evt_if.ready <= 1'b1;
      @(posedge clk);
      while (!evt_if.valid) @(posedge clk);
      got.kind = evt_kind_t'(evt_if.event_kind);
      got.svc  = evt_if.service;
      got.code = evt_if.char_code;
      if (pending_events.size() == 0) begin
        want = '0;
        note_bad("unexpected event", want, got);
      end else begin
        want = pending_events.pop_front();
        if (got.kind != want.kind || got.svc != want.svc || got.code != want.code)
          note_bad("event mismatch", want, got);
      end
    end
  end

  // Watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if ((cap_if.valid && cap_if.ready) || (evt_if.valid && evt_if.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= IDLE_LIMIT) begin
      $display("dtvcc_caption_service_parser: mismatch");
      $finish;
    end
  end

endmodule

@@ sim.f @@
rtl/core/dcsp_pkg.sv
rtl/core/dcsp_if.sv
rtl/core/dcsp_parser.sv
rtl/core/dcsp_counts.sv
rtl/core/dtvcc_caption_service_parser.sv
test/tb_dtvcc_caption_service_parser.sv
